[rtl/acdf_pkg.sv]
`timescale 1ns / 1ps

package acdf_pkg;

  // Default for the longest frame, the '<' and '>' included.
  localparam int unsigned FRAME_MAX_DEF = 16;

  // Bytes kept from a frame: positions 1 to 5. Nothing beyond them is
  // ever needed to decode a frame.
  localparam int unsigned CAP_BYTES = 5;

  localparam logic [7:0] CH_OPEN  = 8'h3C;  // '<'
  localparam logic [7:0] CH_CLOSE = 8'h3E;  // '>'
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'

  localparam logic [2:0] CMD_STOP  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_ZERO  = 3'd2;
  localparam logic [2:0] CMD_FB    = 3'd3;
  localparam logic [2:0] CMD_LR    = 3'd4;

  // Frame length classes, the code being the length up to seven. Every
  // longer frame maps to LEN_OTHER, which decodes as a value of zero.
  localparam logic [2:0] LEN_OTHER = 3'd0;
  localparam logic [2:0] LEN_ONE   = 3'd4;
  localparam logic [2:0] LEN_TWO   = 3'd5;
  localparam logic [2:0] LEN_THREE = 3'd6;
  localparam logic [2:0] LEN_START = 3'd7;

  localparam logic [6:0] VAL_MAX = 7'd100;

  // body[0] holds frame byte 1 (the letter), body[4] holds byte 5.
  typedef struct packed {
    logic [2:0]                len_code;
    logic [CAP_BYTES-1:0][7:0] body;
  } frame_t;

  typedef struct packed {
    logic              accepted;
    logic [2:0]        command;
    logic signed [7:0] value;
  } result_t;

endpackage

[rtl/acdf_framer.sv]
`timescale 1ns / 1ps

module acdf_framer #(
  parameter int unsigned FRAME_MAX = acdf_pkg::FRAME_MAX_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             byte_valid_i,
  input  logic [7:0]       byte_i,
  output logic             byte_ready_o,
  output logic             frame_valid_o,
  output acdf_pkg::frame_t frame_o,
  input  logic             take_i
);

  localparam int unsigned LenW = $clog2(FRAME_MAX + 1);

  logic                                    in_frame_q, in_frame_d;
  logic [LenW-1:0]                         len_q, len_d;
  logic [acdf_pkg::CAP_BYTES-1:0][7:0]     body_q, body_d;
  logic                                    pend_q, pend_d;
  acdf_pkg::frame_t                        frame_q, frame_d;
  logic                                    accept;
  logic                                    closing;

  assign byte_ready_o  = !pend_q || take_i;
  assign accept        = byte_valid_i && byte_ready_o;
  assign frame_valid_o = pend_q;
  assign frame_o       = frame_q;

  always_comb begin
    in_frame_d = in_frame_q;
    len_d      = len_q;
    body_d     = body_q;
    closing    = 1'b0;
    frame_d    = frame_q;
    if (accept) begin
      if (!in_frame_q) begin
        if (byte_i == acdf_pkg::CH_OPEN) begin
          in_frame_d = 1'b1;
          len_d      = LenW'(1);
        end
      end else if (len_q >= LenW'(FRAME_MAX)) begin
        // Overlong frame: dropped without a result.
        in_frame_d = 1'b0;
        len_d      = '0;
      end else begin
        for (int i = 0; i < acdf_pkg::CAP_BYTES; i++) begin
          if (len_q == LenW'(i + 1)) begin
            body_d[i] = byte_i;
          end
        end
        len_d = len_q + LenW'(1);
        if (byte_i == acdf_pkg::CH_CLOSE) begin
          closing    = 1'b1;
          in_frame_d = 1'b0;
          len_d      = '0;
        end
      end
    end
    if (closing) begin
      frame_d.body     = body_d;
      frame_d.len_code = (len_q < LenW'(7)) ? (len_q[2:0] + 3'd1) : acdf_pkg::LEN_OTHER;
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (closing) begin
      pend_d = 1'b1;
    end else if (take_i) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      len_q      <= '0;
      pend_q     <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
      len_q      <= len_d;
      pend_q     <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    body_q  <= body_d;
    frame_q <= frame_d;
  end

endmodule

[rtl/acdf_decoder.sv]
`timescale 1ns / 1ps

module acdf_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              frame_valid_i,
  input  acdf_pkg::frame_t  frame_i,
  output logic              take_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output acdf_pkg::result_t result_o
);

  logic                    out_valid_q, out_valid_d;
  acdf_pkg::result_t       result_q, result_d;
  logic [2:0]              held_cmd_q, held_cmd_d;
  logic signed [7:0]       held_val_q, held_val_d;
  logic                    is_start, is_stop;
  logic signed [9:0]       dig0, dig1, dig2;
  logic signed [15:0]      sum;
  logic [6:0]              mag;
  logic signed [7:0]       pos_val;
  logic                    ok;
  logic                    load;

  assign take_o      = !out_valid_q || out_ready_i;
  assign load        = take_o && frame_valid_i;
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  assign is_start = (frame_i.len_code == acdf_pkg::LEN_START) &&
                    (frame_i.body[0] == acdf_pkg::CH_S) && (frame_i.body[1] == acdf_pkg::CH_T) &&
                    (frame_i.body[2] == acdf_pkg::CH_A) && (frame_i.body[3] == acdf_pkg::CH_R) &&
                    (frame_i.body[4] == acdf_pkg::CH_T);
  assign is_stop  = (frame_i.len_code == acdf_pkg::LEN_THREE) &&
                    (frame_i.body[0] == acdf_pkg::CH_S) && (frame_i.body[1] == acdf_pkg::CH_T) &&
                    (frame_i.body[2] == acdf_pkg::CH_O) && (frame_i.body[3] == acdf_pkg::CH_P);

  // Digit bytes are not checked; any byte is weighted as its offset from '0'.
  assign dig0 = $signed({2'b00, frame_i.body[1]}) - $signed({2'b00, acdf_pkg::CH_ZERO});
  assign dig1 = $signed({2'b00, frame_i.body[2]}) - $signed({2'b00, acdf_pkg::CH_ZERO});
  assign dig2 = $signed({2'b00, frame_i.body[3]}) - $signed({2'b00, acdf_pkg::CH_ZERO});

  always_comb begin
    case (frame_i.len_code)
      acdf_pkg::LEN_ONE:   sum = 16'(dig0);
      acdf_pkg::LEN_TWO:   sum = 16'(dig0) * 16'sd10 + 16'(dig1);
      acdf_pkg::LEN_THREE: sum = 16'(dig0) * 16'sd100 + 16'(dig1) * 16'sd10 + 16'(dig2);
      default:             sum = '0;
    endcase
  end

  always_comb begin
    if (sum < 16'sd0) begin
      mag = '0;
    end else if (sum > 16'sd100) begin
      mag = acdf_pkg::VAL_MAX;
    end else begin
      mag = sum[6:0];
    end
  end

  assign pos_val = $signed({1'b0, mag});

  always_comb begin
    held_cmd_d = held_cmd_q;
    held_val_d = held_val_q;
    ok         = 1'b1;
    if (is_start) begin
      held_cmd_d = acdf_pkg::CMD_START;
    end else if (is_stop) begin
      held_cmd_d = acdf_pkg::CMD_STOP;
    end else if (mag == '0) begin
      held_cmd_d = acdf_pkg::CMD_ZERO;
      held_val_d = '0;
    end else begin
      case (frame_i.body[0])
        acdf_pkg::CH_F: begin
          held_cmd_d = acdf_pkg::CMD_FB;
          held_val_d = pos_val;
        end
        acdf_pkg::CH_B: begin
          held_cmd_d = acdf_pkg::CMD_FB;
          held_val_d = -pos_val;
        end
        acdf_pkg::CH_R: begin
          held_cmd_d = acdf_pkg::CMD_LR;
          held_val_d = pos_val;
        end
        acdf_pkg::CH_L: begin
          held_cmd_d = acdf_pkg::CMD_LR;
          held_val_d = -pos_val;
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    result_d    = result_q;
    if (load) begin
      out_valid_d       = 1'b1;
      result_d.accepted = ok;
      result_d.command  = held_cmd_d;
      result_d.value    = held_val_d;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      held_cmd_q  <= acdf_pkg::CMD_STOP;
      held_val_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (load) begin
        held_cmd_q <= held_cmd_d;
        held_val_q <= held_val_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

endmodule

[rtl/ascii_drive_command_frame_parser.sv]
`timescale 1ns / 1ps
// The result is valid once the transfer of the closing '>' byte has passed the frame
// register and then the output register.
// Throughput: one byte per cycle unless m_axis stalls with the framer register and the
// output register both full; each holds one frame, so bytes flow while one result waits.
// Reset (rst_ni low, asynchronous): the parser hunts for '<', no result is pending,
// and the held command is stop with a held value of zero.

module ascii_drive_command_frame_parser #(
  parameter int unsigned FRAME_MAX = acdf_pkg::FRAME_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Received characters, one per transfer.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // One result per completed frame.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [0] accepted, [3:1] command,
                                      // [11:4] drive_value, [15:12] zero
);

  // The framer follows the '<' ... '>' structure byte by byte, keeps only the
  // letter and the few bytes that decoding can look at, and registers a frame
  // snapshot when '>' arrives. A frame that would grow beyond FRAME_MAX bytes
  // is dropped without a result.
  logic              frame_valid;
  acdf_pkg::frame_t  frame;
  logic              take;
  acdf_pkg::result_t result;

  acdf_framer #(
    .FRAME_MAX(FRAME_MAX)
  ) u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_i       (s_axis_tdata),
    .byte_ready_o (s_axis_tready),
    .frame_valid_o(frame_valid),
    .frame_o      (frame),
    .take_i       (take)
  );

  // The decoder matches START and STOP, weighs the digits, clamps to 0..100,
  // applies the letter and updates the held command and value, all in the
  // cycle that loads the output register.
  acdf_decoder u_decoder (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_valid_i(frame_valid),
    .frame_i      (frame),
    .take_o       (take),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .result_o     (result)
  );

  assign m_axis_tdata = {4'b0000, result.value, result.command, result.accepted};

  // The zero command always carries a value of zero.
  a_zero_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[3:1] == acdf_pkg::CMD_ZERO)) |-> (m_axis_tdata[11:4] == 8'h00))
    else $error("zero command with a nonzero value");

  // The held value never leaves the clamped range.
  a_value_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (($signed(m_axis_tdata[11:4]) <= 8'sd100) &&
                       ($signed(m_axis_tdata[11:4]) >= -8'sd100)))
    else $error("drive value out of range");

  // The input only stalls when both frame registers are full behind a stalled output.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && frame_valid))
    else $error("input stalled without output back-pressure");

endmodule
